FILE: rtl/sarsum_pkg.sv
// shared types and constants for the summed-area rectangle sum core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sarsum_pkg;

    // default sizing
    localparam int MAX_ROWS_DEF  = 64;
    localparam int MAX_COLS_DEF  = 64;
    localparam int CELL_BITS_DEF = 16;

    // fixed field and storage widths
    localparam int BOUND_W = 7;   // query bounds and count registers
    localparam int TABLE_W = 29;  // stored prefix entry
    localparam int RUN_W   = 23;  // running row sum
    localparam int SUM_W   = 28;  // rectangle sum
    localparam int WIDE_W  = 33;  // cell plus running sum before wrap
    localparam int CMP_W   = 11;  // position compares against counts

    localparam int OUT_W   = ((SUM_W + 7) / 8) * 8;

    localparam logic [BOUND_W-1:0] COUNT_RESET = BOUND_W'(64);

    // configuration register indexes
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // result status codes
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LD_WR,
        ST_Q_RD,
        ST_Q_FIN
    } sarsum_state_t;

    typedef struct packed {
        logic [BOUND_W-1:0] row_first;
        logic [BOUND_W-1:0] row_last;
        logic [BOUND_W-1:0] col_first;
        logic [BOUND_W-1:0] col_last;
    } sarsum_bounds_t;

    typedef struct packed {
        logic [SUM_W-1:0] rect_sum;
        logic             status;
    } sarsum_res_t;

    // read in flight for one of the four corner terms
    typedef struct packed {
        logic valid;
        logic neg;
        logic zero;
    } sarsum_pend_t;

endpackage

`default_nettype wire

FILE: rtl/sarsum_table.sv
// prefix table storage: one write port, one read port, registered read data
// depends on sarsum_pkg
`timescale 1ns / 1ps
`default_nettype none

module sarsum_table
    import sarsum_pkg::*;
#(
    parameter int DEPTH  = MAX_ROWS_DEF * MAX_COLS_DEF,
    parameter int ADDR_W = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF)
)
(
    input  wire logic               clk,
    input  wire logic               wr_en,
    input  wire logic [ADDR_W-1:0]  wr_addr,
    input  wire logic [TABLE_W-1:0] wr_data,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  rd_addr,
    output logic      [TABLE_W-1:0] rd_data
);

    logic [TABLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/sarsum_ctrl.sv
// sequencer and datapath: load read-modify-write and four-corner query
// depends on sarsum_pkg, drives the ports of sarsum_table
`timescale 1ns / 1ps
`default_nettype none

module sarsum_ctrl
    import sarsum_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF,
    parameter int ADDR_W    = $clog2(MAX_ROWS_DEF * MAX_COLS_DEF)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 in_kind,
    input  wire logic [CELL_BITS-1:0] in_cell,
    input  wire sarsum_bounds_t       in_bounds,
    input  wire logic [BOUND_W-1:0]   rows_eff,
    input  wire logic [BOUND_W-1:0]   cols_eff,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output sarsum_res_t               res,
    output logic                      mem_wr_en,
    output logic      [ADDR_W-1:0]    mem_wr_addr,
    output logic      [TABLE_W-1:0]   mem_wr_data,
    output logic                      mem_rd_en,
    output logic      [ADDR_W-1:0]    mem_rd_addr,
    input  wire logic [TABLE_W-1:0]   mem_rd_data
);

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);

    sarsum_state_t       state_reg, state_next;
    logic [ROW_W-1:0]    load_row_reg, load_row_next;
    logic [COL_W-1:0]    load_col_reg, load_col_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic                above_zero_reg, above_zero_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    sarsum_bounds_t      bounds_reg, bounds_next;
    logic [1:0]          term_reg, term_next;
    sarsum_pend_t        pend_reg, pend_next;
    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                status_reg, status_next;

    // load side
    logic [ADDR_W-1:0]   above_addr;
    logic [ADDR_W-1:0]   here_addr;
    logic [WIDE_W-1:0]   cell_ext;
    logic [WIDE_W-1:0]   run_ext;
    logic [WIDE_W-1:0]   run_sum;
    logic [CMP_W-1:0]    col_inc;
    logic [CMP_W-1:0]    row_inc;
    logic [ROW_W-1:0]    row_above;

    // query side
    logic                bounds_ok;
    logic [BOUND_W-1:0]  term_row;
    logic [BOUND_W-1:0]  term_col;
    logic [ROW_W+BOUND_W-1:0] term_row_pad;
    logic [COL_W+BOUND_W-1:0] term_col_pad;
    logic                term_zero;
    logic [ADDR_W-1:0]   term_addr;
    logic [SUM_W-1:0]    rd_term;
    logic [SUM_W-1:0]    acc_upd;

    assign row_above  = load_row_reg - ROW_W'(1);
    assign above_addr = ADDR_W'(row_above) * ADDR_W'(MAX_COLS) + ADDR_W'(load_col_reg);
    assign here_addr  = ADDR_W'(load_row_reg) * ADDR_W'(MAX_COLS) + ADDR_W'(load_col_reg);

    assign cell_ext = {{(WIDE_W - CELL_BITS){in_cell[CELL_BITS-1]}}, in_cell};
    assign run_ext  = (load_col_reg == '0) ? '0
                    : {{(WIDE_W - RUN_W){run_reg[RUN_W-1]}}, run_reg};
    assign run_sum  = cell_ext + run_ext;

    assign col_inc = CMP_W'(load_col_reg) + CMP_W'(1);
    assign row_inc = CMP_W'(load_row_reg) + CMP_W'(1);

    assign bounds_ok = (in_bounds.row_first != '0)
                    && (in_bounds.row_first <= in_bounds.row_last)
                    && (in_bounds.row_last <= rows_eff)
                    && (in_bounds.col_first != '0)
                    && (in_bounds.col_first <= in_bounds.col_last)
                    && (in_bounds.col_last <= cols_eff);

    // corner terms: +S(rl,cl) -S(rf-1,cl) -S(rl,cf-1) +S(rf-1,cf-1)
    assign term_row  = term_reg[0] ? bounds_reg.row_first - BOUND_W'(1) : bounds_reg.row_last;
    assign term_col  = term_reg[1] ? bounds_reg.col_first - BOUND_W'(1) : bounds_reg.col_last;
    assign term_zero = (term_row == '0) || (term_col == '0);
    assign term_row_pad = {{ROW_W{1'b0}}, term_row - BOUND_W'(1)};
    assign term_col_pad = {{COL_W{1'b0}}, term_col - BOUND_W'(1)};
    assign term_addr = ADDR_W'(term_row_pad[ROW_W-1:0]) * ADDR_W'(MAX_COLS)
                     + ADDR_W'(term_col_pad[COL_W-1:0]);

    assign rd_term = mem_rd_data[SUM_W-1:0];
    assign acc_upd = (!pend_reg.valid || pend_reg.zero) ? acc_reg
                   : (pend_reg.neg ? acc_reg - rd_term : acc_reg + rd_term);

    assign mem_wr_addr = wr_addr_reg;
    assign mem_wr_data = (above_zero_reg ? '0 : mem_rd_data)
                       + {{(TABLE_W - RUN_W){run_reg[RUN_W-1]}}, run_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            load_row_reg <= '0;
            load_col_reg <= '0;
            run_reg      <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            run_reg      <= run_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        above_zero_reg <= above_zero_next;
        wr_addr_reg    <= wr_addr_next;
        bounds_reg     <= bounds_next;
        term_reg       <= term_next;
        acc_reg        <= acc_next;
        status_reg     <= status_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        load_row_next   = load_row_reg;
        load_col_next   = load_col_reg;
        run_next        = run_reg;
        above_zero_next = above_zero_reg;
        wr_addr_next    = wr_addr_reg;
        bounds_next     = bounds_reg;
        term_next       = term_reg;
        pend_next       = pend_reg;
        acc_next        = acc_reg;
        status_next     = status_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        res.rect_sum    = acc_upd;
        res.status      = status_reg;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        mem_rd_addr     = above_addr;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && in_kind == KIND_LOAD)
                begin
                    // fetch the entry above while the row sum moves on
                    mem_rd_en       = (load_row_reg != '0);
                    above_zero_next = (load_row_reg == '0);
                    wr_addr_next    = here_addr;
                    run_next        = run_sum[RUN_W-1:0];
                    if (col_inc >= CMP_W'(cols_eff))
                    begin
                        load_col_next = '0;
                        if (row_inc >= CMP_W'(rows_eff))
                        begin
                            load_row_next = '0;
                        end
                        else
                        begin
                            load_row_next = row_inc[ROW_W-1:0];
                        end
                    end
                    else
                    begin
                        load_col_next = col_inc[COL_W-1:0];
                    end
                    state_next = ST_LD_WR;
                end
                else if (in_valid)
                begin
                    bounds_next     = in_bounds;
                    acc_next        = '0;
                    term_next       = '0;
                    pend_next.valid = 1'b0;
                    if (bounds_ok)
                    begin
                        status_next = STATUS_OK;
                        state_next  = ST_Q_RD;
                    end
                    else
                    begin
                        status_next = STATUS_BAD;
                        state_next  = ST_Q_FIN;
                    end
                end
            end

            ST_LD_WR:
            begin
                mem_wr_en  = 1'b1;
                state_next = ST_IDLE;
            end

            ST_Q_RD:
            begin
                // issue one corner read, fold in the previous one
                mem_rd_addr    = term_addr;
                mem_rd_en      = !term_zero;
                pend_next.valid = 1'b1;
                pend_next.neg  = term_reg[0] ^ term_reg[1];
                pend_next.zero = term_zero;
                acc_next       = acc_upd;
                term_next      = term_reg + 2'd1;
                if (term_reg == 2'd3)
                begin
                    state_next = ST_Q_FIN;
                end
            end

            ST_Q_FIN:
            begin
                res_valid       = 1'b1;
                acc_next        = acc_upd;
                pend_next.valid = 1'b0;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/summed_area_rect_sum_core.sv
// top level of the summed-area rectangle sum core: ports, count registers,
// output register; depends on sarsum_pkg, sarsum_ctrl, sarsum_table
//
// usage
//   s_* channel: one word per item. s_tuser selects the kind: 0 loads the
//   next matrix cell (row-major), 1 asks for a rectangle sum. loads give no
//   result word; each query gives exactly one word on m_*.
//   m_* channel: m_tdata carries the rectangle sum, m_tuser the status
//   (0 ok, 1 bounds inverted, zero or beyond the counts, sum then 0).
//   cfg_* channel: index 0 writes the row count, index 1 the column count;
//   always ready, meant to be written only while the core is idle.
// timing
//   a load reads the entry above, then writes back.
//   a query makes four corner reads through the single table read port, one
//   each, then the final add, before its result reaches the output register;
//   the core takes no new word until it has returned to idle.
// reset
//   counts return to 64, load position and row sum clear; the table keeps
//   whatever it held and needs no clearing pass.
// stalls
//   one result word is held in the output register; loads keep flowing
//   while it waits, a second query waits at its final step until m_tready.
`timescale 1ns / 1ps
`default_nettype none

module summed_area_rect_sum_core
    import sarsum_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_COLS  = MAX_COLS_DEF,
    parameter int CELL_BITS = CELL_BITS_DEF,
    localparam int IN_BITS  = CELL_BITS + 4 * BOUND_W,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input words
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // cell_value, row_first, row_last, col_first, col_last, zero fill
    input  wire logic [IN_W-1:0]    s_tdata,
    // kind
    input  wire logic               s_tuser,
    // result words
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // rect_sum, zero fill
    output logic      [OUT_W-1:0]   m_tdata,
    // status
    output logic                    m_tuser,
    // register writes
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_addr,
    input  wire logic [BOUND_W-1:0] cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [BOUND_W-1:0] row_count_reg;
    logic [BOUND_W-1:0] col_count_reg;
    logic [BOUND_W-1:0] rows_eff;
    logic [BOUND_W-1:0] cols_eff;

    sarsum_bounds_t     in_bounds;
    logic               res_valid;
    logic               res_ready;
    sarsum_res_t        res;

    logic               out_valid_reg;
    logic [SUM_W-1:0]   out_sum_reg;
    logic               out_status_reg;

    logic               mem_wr_en;
    logic [ADDR_W-1:0]  mem_wr_addr;
    logic [TABLE_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [ADDR_W-1:0]  mem_rd_addr;
    logic [TABLE_W-1:0] mem_rd_data;

    // count registers; a zero count acts as one, an oversize count as the maximum
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= COUNT_RESET;
            col_count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_addr == REG_ROW_COUNT)
            begin
                row_count_reg <= cfg_data;
            end
            if (cfg_addr == REG_COL_COUNT)
            begin
                col_count_reg <= cfg_data;
            end
        end
    end

    assign rows_eff = (row_count_reg == '0) ? BOUND_W'(1)
                    : ((int'(row_count_reg) > MAX_ROWS) ? BOUND_W'(MAX_ROWS) : row_count_reg);
    assign cols_eff = (col_count_reg == '0) ? BOUND_W'(1)
                    : ((int'(col_count_reg) > MAX_COLS) ? BOUND_W'(MAX_COLS) : col_count_reg);

    // unpack the input word, cell value in the lowest bits
    assign in_bounds.row_first = s_tdata[CELL_BITS + 0*BOUND_W +: BOUND_W];
    assign in_bounds.row_last  = s_tdata[CELL_BITS + 1*BOUND_W +: BOUND_W];
    assign in_bounds.col_first = s_tdata[CELL_BITS + 2*BOUND_W +: BOUND_W];
    assign in_bounds.col_last  = s_tdata[CELL_BITS + 3*BOUND_W +: BOUND_W];

    sarsum_ctrl #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .CELL_BITS (CELL_BITS),
        .ADDR_W    (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_cell     (s_tdata[CELL_BITS-1:0]),
        .in_bounds   (in_bounds),
        .rows_eff    (rows_eff),
        .cols_eff    (cols_eff),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    sarsum_table #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // output register: takes a result when empty or being drained
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_sum_reg    <= res.rect_sum;
            out_status_reg <= res.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - SUM_W){1'b0}}, out_sum_reg};
    assign m_tuser  = out_status_reg;

endmodule

`default_nettype wire

FILE: test/tb_summed_area_rect_sum_core.sv
// self-checking bench for summed_area_rect_sum_core: cell loads and rectangle queries
// against an in-bench summed-area predictor, with random idling on both stream sides
// depends on sarsum_pkg and summed_area_rect_sum_core
`timescale 1ns / 1ps

module tb_summed_area_rect_sum_core;
    import sarsum_pkg::*;

    // input word layout, lowest bit first: cell_value, row_first, row_last,
    // col_first, col_last, zero fill up to whole bytes
    localparam int CELL_W  = CELL_BITS_DEF;
    localparam int RF_LSB  = CELL_W;
    localparam int RL_LSB  = RF_LSB + BOUND_W;
    localparam int CF_LSB  = RL_LSB + BOUND_W;
    localparam int CL_LSB  = CF_LSB + BOUND_W;
    localparam int IN_W    = ((CELL_W + 4 * BOUND_W + 7) / 8) * 8;
    localparam int FILL_W  = IN_W - CELL_W - 4 * BOUND_W;
    localparam int DEPTH   = MAX_ROWS_DEF * MAX_COLS_DEF;

    // quiet tail that lets the last query or load finish, with a generous margin
    localparam int SETTLE      = 12;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_WORDS = 150;
    localparam int N_PHASES    = 12;

    typedef struct packed {
        logic               kind;
        logic [CELL_W-1:0]  cell_val;
        logic [BOUND_W-1:0] rf;
        logic [BOUND_W-1:0] rl;
        logic [BOUND_W-1:0] cf;
        logic [BOUND_W-1:0] cl;
    } cell_item_t;

    typedef enum logic [1:0] {
        RX_OPEN,    // always ready
        RX_COIN,    // ready half the time
        RX_CHOKE,   // ready with probability one in four
        RX_BEAT     // fixed five-of-eight duty
    } rx_style_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata   = '0;
    logic               s_tuser   = KIND_LOAD;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [OUT_W-1:0]   m_tdata;
    logic               m_tuser;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic               cfg_addr  = REG_ROW_COUNT;
    logic [BOUND_W-1:0] cfg_data  = '0;

    summed_area_rect_sum_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial forever #5 clk = ~clk;

    // words waiting to be sent, and rectangle sums still owed by the core
    cell_item_t  cell_words[$];
    sarsum_res_t sums_due[$];

    // predictor state, advanced only on accepted words
    logic signed [TABLE_W-1:0] sat_entry [DEPTH];
    logic signed [RUN_W-1:0]   row_acc = '0;
    int                        ld_row = 0;
    int                        ld_col = 0;
    logic [BOUND_W-1:0]        rows_reg = COUNT_RESET;
    logic [BOUND_W-1:0]        cols_reg = COUNT_RESET;

    // stimulus-side view: where the next load lands and which entries hold data,
    // so that no query and no load ever reads a table entry never written
    bit                 cell_written [DEPTH];
    int                 plan_row = 0;
    int                 plan_col = 0;
    logic [BOUND_W-1:0] plan_rows_reg = COUNT_RESET;
    logic [BOUND_W-1:0] plan_cols_reg = COUNT_RESET;

    int fail_count   = 0;
    int loads_seen   = 0;
    int queries_seen = 0;
    int bad_seen     = 0;
    int settings_run = 0;

    // a count of 0 behaves as 1, anything above the maximum as the maximum
    function automatic int eff_count(input logic [BOUND_W-1:0] v, input int maxv);
        if (v == 0)
            return 1;
        return (int'(v) > maxv) ? maxv : int'(v);
    endfunction

    // row-major step of the load position, wrapping on both counts
    function automatic void step_pos(inout int r, inout int c, input int rows, input int cols);
        c++;
        if (c >= cols)
        begin
            c = 0;
            r++;
            if (r >= rows)
                r = 0;
        end
    endfunction

    // 1-based table read, row 0 and column 0 read as zero
    function automatic logic signed [31:0] sat_at(input int r, input int c);
        if (r == 0 || c == 0)
            return '0;
        return sat_entry[(r - 1) * MAX_COLS_DEF + (c - 1)];
    endfunction

    // fold one cell into the running row sum and the summed-area table
    function automatic void absorb_cell(input logic signed [CELL_W-1:0] v);
        logic signed [TABLE_W-1:0] above;
        if (ld_col == 0)
            row_acc = v;
        else
            row_acc = row_acc + v;
        if (ld_row == 0)
            above = '0;
        else
            above = sat_entry[(ld_row - 1) * MAX_COLS_DEF + ld_col];
        sat_entry[ld_row * MAX_COLS_DEF + ld_col] = above + row_acc;
        step_pos(ld_row, ld_col, eff_count(rows_reg, MAX_ROWS_DEF),
                 eff_count(cols_reg, MAX_COLS_DEF));
    endfunction

    // four-corner rectangle sum, or the bad-bounds answer
    function automatic sarsum_res_t rect_query(input logic [BOUND_W-1:0] rf,
                                               input logic [BOUND_W-1:0] rl,
                                               input logic [BOUND_W-1:0] cf,
                                               input logic [BOUND_W-1:0] cl);
        sarsum_res_t       r;
        int                rows;
        int                cols;
        logic signed [31:0] s;
        rows = eff_count(rows_reg, MAX_ROWS_DEF);
        cols = eff_count(cols_reg, MAX_COLS_DEF);
        if (rf >= 1 && rf <= rl && int'(rl) <= rows && cf >= 1 && cf <= cl && int'(cl) <= cols)
        begin
            s = sat_at(rl, cl) - sat_at(rf - 1, cl) - sat_at(rl, cf - 1)
              + sat_at(rf - 1, cf - 1);
            r.rect_sum = s[SUM_W-1:0];
            r.status   = STATUS_OK;
        end
        else
        begin
            r.rect_sum = '0;
            r.status   = STATUS_BAD;
        end
        return r;
    endfunction

    function automatic bit corner_ready(input int r, input int c);
        return (r == 0 || c == 0) || cell_written[(r - 1) * MAX_COLS_DEF + (c - 1)];
    endfunction

    function automatic logic [CELL_W-1:0] rand_cell();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return CELL_W'($urandom);
        endcase
    endfunction

    // queue one load; the bound fields are ignored by the core, so fill them with noise
    task automatic plan_load(input logic [CELL_W-1:0] v);
        cell_item_t it;
        it.kind     = KIND_LOAD;
        it.cell_val = v;
        it.rf       = BOUND_W'($urandom);
        it.rl       = BOUND_W'($urandom);
        it.cf       = BOUND_W'($urandom);
        it.cl       = BOUND_W'($urandom);
        cell_words.push_back(it);
        cell_written[plan_row * MAX_COLS_DEF + plan_col] = 1'b1;
        step_pos(plan_row, plan_col, eff_count(plan_rows_reg, MAX_ROWS_DEF),
                 eff_count(plan_cols_reg, MAX_COLS_DEF));
    endtask

    // queue one query; cell_value is ignored for queries, so it carries noise
    task automatic plan_query(input logic [BOUND_W-1:0] rf, input logic [BOUND_W-1:0] rl,
                              input logic [BOUND_W-1:0] cf, input logic [BOUND_W-1:0] cl);
        cell_item_t it;
        it.kind     = KIND_QUERY;
        it.cell_val = CELL_W'($urandom);
        it.rf       = rf;
        it.rl       = rl;
        it.cf       = cf;
        it.cl       = cl;
        cell_words.push_back(it);
    endtask

    // sender idle, every owed sum delivered, then a quiet tail for a trailing load
    task automatic wait_drained(input int tail);
        @(negedge clk);
        while (cell_words.size() != 0 || s_tvalid || sums_due.size() != 0)
            @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_count(input logic addr, input logic [BOUND_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // new counts only while the core is idle; widening the columns is only safe at the
    // start of a matrix, so first finish the current row with a single-row count
    task automatic set_counts(input logic [BOUND_W-1:0] new_rows,
                              input logic [BOUND_W-1:0] new_cols);
        wait_drained(SETTLE);
        if (eff_count(new_cols, MAX_COLS_DEF) > eff_count(plan_cols_reg, MAX_COLS_DEF)
            && (plan_row != 0 || plan_col != 0))
        begin
            write_count(REG_ROW_COUNT, BOUND_W'(1));
            plan_rows_reg = BOUND_W'(1);
            @(negedge clk);
            while (plan_row != 0 || plan_col != 0)
                plan_load(rand_cell());
            wait_drained(SETTLE);
        end
        write_count(REG_ROW_COUNT, new_rows);
        write_count(REG_COL_COUNT, new_cols);
        plan_rows_reg = new_rows;
        plan_cols_reg = new_cols;
        settings_run++;
        @(negedge clk);
    endtask

    // sender: bursts of random length, random gaps, sometimes long gap-free stretches
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin : drive_words
        cell_item_t it;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cell_words.size() == 0)
                s_tvalid <= 1'b0;
            else
            begin
                it = cell_words.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.kind;
                s_tdata  <= {{FILL_W{1'b0}}, it.cl, it.cf, it.rl, it.rf, it.cell_val};
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // receiver: switches to a randomly chosen stall style whenever its current span runs out
    rx_style_t rx_style = RX_OPEN;
    int        rx_span  = 0;
    int        rx_tick  = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_span  <= 0;
        end
        else
        begin
            rx_tick <= rx_tick + 1;
            if (rx_span == 0)
            begin
                rx_style <= rx_style_t'($urandom_range(0, 3));
                rx_span  <= $urandom_range(20, 200);
            end
            else
                rx_span <= rx_span - 1;
            case (rx_style)
                RX_OPEN:  m_tready <= 1'b1;
                RX_COIN:  m_tready <= 1'($urandom_range(0, 1));
                RX_CHOKE: m_tready <= ($urandom_range(0, 3) == 0);
                default:  m_tready <= ((rx_tick % 8) < 5);
            endcase
        end
    end

    // monitor: check delivered sums first, then register writes, then fold accepted words
    // into the predictor; a query accepted at this edge cannot be answered at the same edge
    always @(posedge clk)
    begin : watch_ports
        sarsum_res_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (sums_due.size() == 0)
                begin
                    $display("%0t: result word with nothing owed, sum %0d status %0b",
                             $time, $signed(m_tdata[SUM_W-1:0]), m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (m_tdata[SUM_W-1:0] !== want.rect_sum)
                    begin
                        $display("%0t: rect_sum mismatch, expected %0d, actual %0d", $time,
                                 $signed(want.rect_sum), $signed(m_tdata[SUM_W-1:0]));
                        fail_count++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0b, actual %0b",
                                 $time, want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_addr == REG_ROW_COUNT)
                    rows_reg = cfg_data;
                else
                    cols_reg = cfg_data;
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == KIND_LOAD)
                begin
                    absorb_cell(s_tdata[CELL_W-1:0]);
                    loads_seen++;
                end
                else
                begin
                    want = rect_query(s_tdata[RF_LSB +: BOUND_W], s_tdata[RL_LSB +: BOUND_W],
                                      s_tdata[CF_LSB +: BOUND_W], s_tdata[CL_LSB +: BOUND_W]);
                    sums_due.push_back(want);
                    queries_seen++;
                    if (want.status == STATUS_BAD)
                        bad_seen++;
                end
            end
        end
    end

    // watchdog on cycles where no word moves on any channel
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // count settings per phase: extremes, zero (acts as 1), above range (acts as 64)
    int phase_rows [N_PHASES] = '{64, 5, 1, 0, 127, 8, 2, 16, 3, 64, 12, 1};
    int phase_cols [N_PHASES] = '{64, 7, 1, 3, 2, 64, 0, 9, 127, 1, 12, 40};

    initial
    begin
        int                 ph;
        int                 done;
        int                 run;
        int                 k;
        int                 tries;
        int                 rows;
        int                 cols;
        int                 lim;
        bit                 found;
        logic [BOUND_W-1:0] rf;
        logic [BOUND_W-1:0] rl;
        logic [BOUND_W-1:0] cf;
        logic [BOUND_W-1:0] cl;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: a 3 x 4 matrix with extreme cells, a query on the partial matrix,
        // corner and inner rectangles, and each way the bounds can be bad
        set_counts(BOUND_W'(3), BOUND_W'(4));
        plan_load(16'h7fff);
        plan_load(16'h8000);
        plan_load(16'h7fff);
        plan_load(16'h8000);
        plan_query(1, 1, 1, 4);
        plan_load(16'hffff);
        plan_load(16'h0000);
        plan_load(16'h0001);
        plan_load(16'h7fff);
        plan_load(16'h8000);
        plan_load(16'h8000);
        plan_load(16'd12345);
        plan_load(16'hffff);
        plan_query(1, 3, 1, 4);
        plan_query(1, 1, 1, 1);
        plan_query(3, 3, 4, 4);
        plan_query(2, 3, 2, 3);
        plan_query(0, 1, 1, 1);          // zero first row
        plan_query(2, 1, 1, 1);          // rows inverted
        plan_query(1, 4, 1, 1);          // last row past the count
        plan_query(1, 1, 0, 1);          // zero first column
        plan_query(1, 1, 3, 2);          // columns inverted
        plan_query(1, 1, 1, 5);          // last column past the count
        plan_query(127, 127, 127, 127);  // all bound bits set
        wait_drained(SETTLE);

        // random phases: runs of loads forming matrices, interleaved with query runs
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            set_counts(BOUND_W'(phase_rows[ph]), BOUND_W'(phase_cols[ph]));
            rows = eff_count(plan_rows_reg, MAX_ROWS_DEF);
            cols = eff_count(plan_cols_reg, MAX_COLS_DEF);
            done = 0;
            while (done < PHASE_WORDS)
            begin
                if ($urandom_range(0, 9) < 6)
                begin
                    run = $urandom_range(1, 2 * cols);
                    for (k = 0; k < run; k++)
                        plan_load(rand_cell());
                end
                else
                begin
                    run = $urandom_range(1, 6);
                    for (k = 0; k < run; k++)
                    begin
                        // mostly good bounds over entries that hold data, the rest bad
                        found = 1'b0;
                        if ($urandom_range(0, 4) != 0)
                        begin
                            for (tries = 0; tries < 40 && !found; tries++)
                            begin
                                lim = (tries % 2 == 0 && plan_row > 0) ? plan_row : rows;
                                rl  = BOUND_W'($urandom_range(1, lim));
                                rf  = BOUND_W'($urandom_range(1, rl));
                                cl  = BOUND_W'($urandom_range(1, cols));
                                cf  = BOUND_W'($urandom_range(1, cl));
                                found = corner_ready(rl, cl) && corner_ready(rf - 1, cl)
                                     && corner_ready(rl, cf - 1)
                                     && corner_ready(rf - 1, cf - 1);
                            end
                        end
                        if (!found)
                        begin
                            rf = BOUND_W'($urandom);
                            rl = BOUND_W'($urandom);
                            cf = BOUND_W'($urandom);
                            cl = BOUND_W'($urandom);
                            case ($urandom_range(0, 5))
                                0: rf = '0;
                                1: cf = '0;
                                2: rl = BOUND_W'($urandom_range(rows + 1, 127));
                                3: cl = BOUND_W'($urandom_range(cols + 1, 127));
                                4:
                                begin
                                    rl = BOUND_W'($urandom_range(0, 126));
                                    rf = BOUND_W'($urandom_range(rl + 1, 127));
                                end
                                default:
                                begin
                                    cl = BOUND_W'($urandom_range(0, 126));
                                    cf = BOUND_W'($urandom_range(cl + 1, 127));
                                end
                            endcase
                        end
                        plan_query(rf, rl, cf, cl);
                    end
                end
                done += run;
            end
        end

        wait_drained(2 * SETTLE);
        $display("ran %0d cell loads and %0d rectangle queries (%0d with bad bounds)",
                 loads_seen, queries_seen, bad_seen);
        $display("over %0d row/column count settings, %0d mismatches", settings_run,
                 fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
